// ----- sv/psfmap_pkg.sv -----
// Shared types and constants for the PSF font Unicode map parser.
`default_nettype none
package psfmap_pkg;

	localparam int OFFSET_BITS_DEF = 32;

	// Parser phase, one-hot.
	typedef enum logic [3:0] {
		PH_HEADER = 4'b0001,
		PH_SKIP   = 4'b0010,
		PH_TABLE  = 4'b0100,
		PH_DONE   = 4'b1000
	} phase_t;

	// Load status codes.
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_MAGIC = 3'd1;
	localparam logic [2:0] ST_NO_TABLE  = 3'd2;
	localparam logic [2:0] ST_GEOMETRY  = 3'd3;
	localparam logic [2:0] ST_TRUNCATED = 3'd4;
	localparam logic [2:0] ST_EMPTY     = 3'd5;

	localparam logic [31:0] PSF2_SIGNATURE = 32'h864a_b572;

	// One result item.
	typedef struct packed {
		logic        kind;
		logic [20:0] codepoint;
		logic [31:0] glyph;
		logic [31:0] offset;
		logic [7:0]  width;
		logic [7:0]  height;
		logic [2:0]  status;
		logic [31:0] total;
		logic        last;
	} res_t;

	// Results produced by one byte: count and up to two items.
	typedef struct packed {
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} push_t;

endpackage
`default_nettype wire

// ----- sv/psfmap_core.sv -----
// Parser state and per-byte next-state logic.
`default_nettype none
module psfmap_core #(
	parameter int OFFSET_BITS = psfmap_pkg::OFFSET_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              fire,
	input  wire logic [7:0]        data_byte,
	input  wire logic              end_of_file,
	output psfmap_pkg::push_t      push
);
	import psfmap_pkg::*;

	localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};
	localparam logic [64:0] POS_MAX_W = {{(65-OFFSET_BITS){1'b0}}, POS_MAX};

	// Table start = base + prod, saturated at POS_MAX.
	function automatic logic [OFFSET_BITS-1:0] ts_sat(input logic [31:0] base,
		input logic [63:0] prod);
		logic [64:0] b65;
		logic [64:0] p65;
		logic [64:0] s65;
		b65 = {33'b0, base};
		p65 = {1'b0, prod};
		s65 = b65 + p65;
		if (b65 >= POS_MAX_W || p65 >= POS_MAX_W || s65 >= POS_MAX_W)
			ts_sat = POS_MAX;
		else
			ts_sat = s65[OFFSET_BITS-1:0];
	endfunction

	phase_t                 phase_q, phase_d;
	logic [OFFSET_BITS-1:0] pos_q, pos_d;
	logic                   v2_q, v2_d;
	logic [7:0]             hdr_q [32];
	logic [31:0]            gtot_q, gtot_d;
	logic [31:0]            bpg_q, bpg_d;
	logic [OFFSET_BITS-1:0] tstart_q, tstart_d;
	logic                   tpend_q, tpend_d;
	logic [63:0]            prod_s1, prod_d;
	logic [31:0]            tbase_q, tbase_d;
	logic [31:0]            cglyph_q, cglyph_d;
	logic [31:0]            coff_q, coff_d;
	logic                   seq_q, seq_d;
	logic [20:0]            acc_q, acc_d;
	logic [1:0]             left_q, left_d;
	logic [8:0]             hold_q, hold_d;
	logic [31:0]            ent_q, ent_d;
	logic [2:0]             err_q, err_d;

	logic [7:0]  hv [32];
	logic [31:0] h_hsz, h_flags, h_cnt, h_sz, h_h, h_w;
	logic [5:0]  w_bytes;
	logic [13:0] geo_sz;

	// Header view including the byte now arriving.
	always_comb begin
		for (int i = 0; i < 32; i++) begin
			hv[i] = (pos_q == OFFSET_BITS'(i)) ? data_byte : hdr_q[i];
		end
		h_hsz   = {hv[11], hv[10], hv[9], hv[8]};
		h_flags = {hv[15], hv[14], hv[13], hv[12]};
		h_cnt   = {hv[19], hv[18], hv[17], hv[16]};
		h_sz    = {hv[23], hv[22], hv[21], hv[20]};
		h_h     = {hv[27], hv[26], hv[25], hv[24]};
		h_w     = {hv[31], hv[30], hv[29], hv[28]};
		w_bytes = 6'(({1'b0, h_w[7:0]} + 9'd7) >> 3);
		geo_sz  = w_bytes * h_h[7:0];
	end

	always_comb begin
		res_t       ent_r;
		res_t       st_r;
		logic       emit;
		logic       tb;
		logic       nextg;
		logic [20:0] ecp;
		logic [15:0] word;
		logic [2:0]  st;

		phase_d = phase_q; pos_d = pos_q; v2_d = v2_q; gtot_d = gtot_q; bpg_d = bpg_q;
		tstart_d = tstart_q; tpend_d = tpend_q; prod_d = prod_s1; tbase_d = tbase_q;
		cglyph_d = cglyph_q; coff_d = coff_q; seq_d = seq_q; acc_d = acc_q;
		left_d = left_q; hold_d = hold_q; ent_d = ent_q; err_d = err_q;
		emit = 1'b0; tb = 1'b0; nextg = 1'b0; ecp = '0; word = '0; st = ST_OK;
		ent_r = '0; st_r = '0;
		push = '0;

		// Finish the PSF2 table start from the registered product.
		if (tpend_q) begin
			tstart_d = ts_sat(tbase_q, prod_s1);
			tpend_d  = 1'b0;
		end

		if (fire) begin
			unique case (phase_q)
				PH_HEADER: begin
					if (pos_q == OFFSET_BITS'(3) && hv[0] == 8'h36 && hv[1] == 8'h04) begin
						v2_d = 1'b0;
						if (hv[2][2:1] == 2'b00) begin
							err_d = ST_NO_TABLE; phase_d = PH_DONE;
						end else begin
							gtot_d = hv[2][0] ? 32'd512 : 32'd256;
							bpg_d  = {24'b0, hv[3]};
							if (hv[3] == 8'h00) begin
								err_d = ST_TRUNCATED; phase_d = PH_DONE;
							end else begin
								tstart_d = ts_sat(32'd4, hv[2][0] ? {47'b0, hv[3], 9'b0}
									: {48'b0, hv[3], 8'b0});
								coff_d  = 32'd4;
								phase_d = PH_SKIP;
							end
						end
					end else if (pos_q == OFFSET_BITS'(31)) begin
						if ({hv[3], hv[2], hv[1], hv[0]} != PSF2_SIGNATURE) begin
							err_d = ST_BAD_MAGIC; phase_d = PH_DONE;
						end else begin
							v2_d   = 1'b1;
							gtot_d = h_cnt;
							bpg_d  = h_sz;
							if (!h_flags[0]) begin
								err_d = ST_NO_TABLE; phase_d = PH_DONE;
							end else if (h_w == 32'd0 || h_h == 32'd0 || h_w > 32'd255
								|| h_h > 32'd255 || h_hsz < 32'd32
								|| h_sz != {18'b0, geo_sz}) begin
								err_d = ST_GEOMETRY; phase_d = PH_DONE;
							end else if (h_cnt == 32'd0) begin
								err_d = ST_TRUNCATED; phase_d = PH_DONE;
							end else begin
								prod_d  = {32'b0, h_cnt} * {32'b0, h_sz};
								tbase_d = h_hsz;
								tpend_d = 1'b1;
								coff_d  = h_hsz;
								phase_d = PH_SKIP;
							end
						end
					end
				end
				PH_SKIP: begin
					if (!tpend_q && pos_q == tstart_q) begin
						phase_d = PH_TABLE;
						tb = 1'b1;
					end
				end
				PH_TABLE: tb = 1'b1;
				PH_DONE: ;
				default: ;
			endcase

			if (tb) begin
				if (!v2_q) begin
					if (!hold_q[8]) begin
						hold_d = {1'b1, data_byte};
					end else begin
						word   = {data_byte, hold_q[7:0]};
						hold_d = '0;
						if (word == 16'hFFFF) nextg = 1'b1;
						else if (word == 16'hFFFE) seq_d = 1'b1;
						else if (!seq_q) begin
							emit = 1'b1; ecp = {5'b0, word};
						end
					end
				end else if (left_q != 2'd0) begin
					acc_d  = {acc_q[14:0], data_byte[5:0]};
					left_d = left_q - 2'd1;
					if (left_q == 2'd1 && !seq_q && acc_d != 21'd0) begin
						emit = 1'b1; ecp = acc_d;
					end
				end else if (data_byte == 8'hFF) nextg = 1'b1;
				else if (data_byte == 8'hFE) seq_d = 1'b1;
				else if (!data_byte[7]) begin
					if (!seq_q && data_byte != 8'h00) begin
						emit = 1'b1; ecp = {14'b0, data_byte[6:0]};
					end
				end else if (data_byte[7:5] == 3'b110) begin
					acc_d = {16'b0, data_byte[4:0]}; left_d = 2'd1;
				end else if (data_byte[7:4] == 4'b1110) begin
					acc_d = {17'b0, data_byte[3:0]}; left_d = 2'd2;
				end else if (data_byte[7:3] == 5'b11110) begin
					acc_d = {18'b0, data_byte[2:0]}; left_d = 2'd3;
				end
			end

			if (nextg) begin
				cglyph_d = cglyph_q + 32'd1;
				coff_d   = coff_q + bpg_q;
				seq_d    = 1'b0;
				if (cglyph_d >= gtot_q) phase_d = PH_DONE;
			end

			if (emit) begin
				ent_r.codepoint = ecp;
				ent_r.glyph     = cglyph_q;
				ent_r.offset    = coff_q;
				ent_r.width     = v2_q ? hdr_q[28] : 8'd8;
				ent_r.height    = v2_q ? hdr_q[24] : hdr_q[3];
				ent_r.last      = 1'b1;
				if (ent_q != 32'hFFFF_FFFF) ent_d = ent_q + 32'd1;
			end

			if (pos_q != POS_MAX) pos_d = pos_q + 1'b1;

			if (!end_of_file) begin
				push.n  = emit ? 2'd1 : 2'd0;
				push.r0 = ent_r;
			end else begin
				if (phase_d == PH_HEADER) st = ST_BAD_MAGIC;
				else if (phase_d == PH_SKIP) st = ST_TRUNCATED;
				else if (err_d != ST_OK) st = err_d;
				else st = (ent_d != 32'd0) ? ST_OK : ST_EMPTY;
				st_r.kind   = 1'b1;
				st_r.status = st;
				st_r.total  = ent_d;
				st_r.last   = 1'b1;
				if (emit) begin
					ent_r.last = 1'b0;
					push.n  = 2'd2;
					push.r0 = ent_r;
					push.r1 = st_r;
				end else begin
					push.n  = 2'd1;
					push.r0 = st_r;
				end
				// Back to the reset state for the next file.
				phase_d = PH_HEADER; pos_d = '0; v2_d = 1'b0; gtot_d = '0; bpg_d = '0;
				tstart_d = '0; tpend_d = 1'b0; tbase_d = '0; cglyph_d = '0; coff_d = '0;
				seq_d = 1'b0; acc_d = '0; left_d = '0; hold_d = '0; ent_d = '0;
				err_d = ST_OK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			pos_q    <= '0;
			v2_q     <= 1'b0;
			gtot_q   <= '0;
			bpg_q    <= '0;
			tstart_q <= '0;
			tpend_q  <= 1'b0;
			tbase_q  <= '0;
			cglyph_q <= '0;
			coff_q   <= '0;
			seq_q    <= 1'b0;
			acc_q    <= '0;
			left_q   <= '0;
			hold_q   <= '0;
			ent_q    <= '0;
			err_q    <= ST_OK;
		end else begin
			phase_q  <= phase_d;
			pos_q    <= pos_d;
			v2_q     <= v2_d;
			gtot_q   <= gtot_d;
			bpg_q    <= bpg_d;
			tstart_q <= tstart_d;
			tpend_q  <= tpend_d;
			tbase_q  <= tbase_d;
			cglyph_q <= cglyph_d;
			coff_q   <= coff_d;
			seq_q    <= seq_d;
			acc_q    <= acc_d;
			left_q   <= left_d;
			hold_q   <= hold_d;
			ent_q    <= ent_d;
			err_q    <= err_d;
		end
	end

	// Product register and header bytes: payload, no reset.
	always_ff @(posedge clk) begin
		prod_s1 <= prod_d;
		if (fire && phase_q == PH_HEADER && pos_q < OFFSET_BITS'(32))
			hdr_q[pos_q[4:0]] <= data_byte;
	end

	a_tpend_skip: assert property (@(posedge clk) disable iff (!arst_n)
		tpend_q |-> phase_q == PH_SKIP)
		else $error("table start pending outside skip phase");
	a_two_only_eof: assert property (@(posedge clk) disable iff (!arst_n)
		push.n == 2'd2 |-> fire && end_of_file)
		else $error("two results from a byte that is not the last");
	a_reset_after_eof: assert property (@(posedge clk) disable iff (!arst_n)
		fire && end_of_file |=> phase_q == PH_HEADER && pos_q == '0)
		else $error("parser not back at start after end of file");

endmodule
`default_nettype wire

// ----- sv/psfmap_outq.sv -----
// Four-entry result queue between the parser and the output channel.
`default_nettype none
module psfmap_outq (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire psfmap_pkg::push_t push,
	output logic                   full,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output psfmap_pkg::res_t       head
);
	import psfmap_pkg::*;

	res_t       ent_q [4];
	logic [2:0] cnt_q;
	logic       pop;
	logic [2:0] base;

	assign out_valid = cnt_q != 3'd0;
	assign pop       = out_valid && !out_stall;
	assign full      = cnt_q >= 3'd3;
	assign head      = ent_q[0];
	assign base      = cnt_q - {2'b0, pop};

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			if (push.n != 2'd0 && base == 3'(i))
				ent_q[i] <= push.r0;
			else if (push.n == 2'd2 && base == 3'(i - 1))
				ent_q[i] <= push.r1;
			else if (pop && i < 3)
				ent_q[i] <= ent_q[i + 1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= base + {1'b0, push.n};
		end
	end

	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 3'd4)
		else $error("result queue overflow");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.n != 2'd0 |-> cnt_q <= 3'd2)
		else $error("push into a queue without room");
	a_head_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(head))
		else $error("stalled result changed");

endmodule
`default_nettype wire

// ----- sv/psf_font_unicode_map_parser.sv -----
// Top level of the PSF1/PSF2 font Unicode map parser.
// A byte's results are written to the registered result queue as it is accepted,
// and reach the output port from the queue head, after any earlier results.
// Throughput: one byte per cycle unless in_stall, set at three of four queued;
// the final byte can give two results, drained one per cycle unless out_stall.
// Reset (arst_n low, asynchronous) returns the parser to magic detection with an
// empty queue; after every end_of_file byte the parser restarts on its own.
`default_nettype none
module psf_font_unicode_map_parser #(
	parameter int OFFSET_BITS = psfmap_pkg::OFFSET_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        end_of_file,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             result_kind,
	output logic [20:0]      codepoint,
	output logic [31:0]      glyph_number,
	output logic [31:0]      bitmap_offset,
	output logic [7:0]       glyph_width,
	output logic [7:0]       glyph_height,
	output logic [2:0]       status_code,
	output logic [31:0]      entry_total,
	output logic             last_of_run
);
	import psfmap_pkg::*;

	logic  fire;
	logic  full;
	push_t push;
	res_t  head;

	// Stall only on the queue level, so a byte is taken while results wait.
	assign in_stall = full;
	assign fire     = in_valid && !in_stall;

	// Header decode, table skip, PSF1 word / PSF2 UTF-8 decode.
	psfmap_core #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.data_byte  (data_byte),
		.end_of_file(end_of_file),
		.push       (push)
	);

	// Result queue: absorbs the entry plus status pair of the last byte.
	psfmap_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.head     (head)
	);

	assign result_kind   = head.kind;
	assign codepoint     = head.codepoint;
	assign glyph_number  = head.glyph;
	assign bitmap_offset = head.offset;
	assign glyph_width   = head.width;
	assign glyph_height  = head.height;
	assign status_code   = head.status;
	assign entry_total   = head.total;
	assign last_of_run   = head.last;

endmodule
`default_nettype wire
